[rtl/assert_macros.svh]
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define VSLPF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define VSLPF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/vslpf_pkg.sv]
// Shared constants, types and state encoding of the variable-step low-pass filter.
`default_nettype none
package vslpf_pkg;

  localparam int SAMPLE_WIDTH  = 24;
  localparam int FRACTION_BITS = 16;
  localparam int DELTA_WIDTH   = 16;
  localparam int TC_WIDTH      = 16;

  localparam int DEN_WIDTH   = DELTA_WIDTH + 1;
  localparam int REM_WIDTH   = DEN_WIDTH + 1;
  localparam int ALPHA_WIDTH = FRACTION_BITS + 1;
  localparam int DIFF_WIDTH  = SAMPLE_WIDTH + 1;
  localparam int PROD_WIDTH  = DIFF_WIDTH + ALPHA_WIDTH + 1;
  localparam int DIV_STEPS   = FRACTION_BITS + 1;
  localparam int CNT_WIDTH   = $clog2(DIV_STEPS);

  localparam logic [TC_WIDTH-1:0] TC_RESET = TC_WIDTH'(1000);

  localparam int PADDR_WIDTH = 3;
  localparam int PDATA_WIDTH = 32;
  localparam int REG_IDX_WIDTH = PADDR_WIDTH - 2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_TIME_CONSTANT = REG_IDX_WIDTH'(0);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic commit;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/vslpf_regs.sv]
// APB configuration register bank holding the filter time constant.
`default_nettype none
module vslpf_regs (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    psel,
  input  wire                                    penable,
  input  wire                                    pwrite,
  input  wire  [vslpf_pkg::PADDR_WIDTH-1:0]      paddr,
  input  wire  [vslpf_pkg::PDATA_WIDTH-1:0]      pwdata,
  output logic [vslpf_pkg::PDATA_WIDTH-1:0]      prdata,
  output logic                                   pready,
  output logic [vslpf_pkg::TC_WIDTH-1:0]         time_constant
);

  logic [vslpf_pkg::TC_WIDTH-1:0]      tc_r;
  logic [vslpf_pkg::TC_WIDTH-1:0]      tc_nxt;
  logic [vslpf_pkg::REG_IDX_WIDTH-1:0] reg_idx;
  logic                                wr_en;

  assign reg_idx = paddr[vslpf_pkg::PADDR_WIDTH-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    tc_nxt = tc_r;
    if (wr_en && (reg_idx == vslpf_pkg::REG_TIME_CONSTANT)) begin
      tc_nxt = pwdata[vslpf_pkg::TC_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == vslpf_pkg::REG_TIME_CONSTANT) begin
      prdata = vslpf_pkg::PDATA_WIDTH'(tc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= vslpf_pkg::TC_RESET;
    end else begin
      tc_r <= tc_nxt;
    end
  end

  assign time_constant = tc_r;

endmodule
`default_nettype wire

[rtl/vslpf_ctrl.sv]
// Controller state machine that sequences divide, multiply and update for each request.
`default_nettype none
module vslpf_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               out_ready,
  output logic              out_valid,
  output vslpf_pkg::cmd_t   cmd
);

  vslpf_pkg::state_t state_r;
  vslpf_pkg::state_t state_nxt;
  logic [vslpf_pkg::CNT_WIDTH-1:0] cnt_r;
  logic [vslpf_pkg::CNT_WIDTH-1:0] cnt_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic slot_free;

  localparam logic [vslpf_pkg::CNT_WIDTH-1:0] CNT_LAST =
    vslpf_pkg::CNT_WIDTH'(vslpf_pkg::DIV_STEPS - 1);

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      vslpf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = vslpf_pkg::ST_DIV;
        end
      end
      vslpf_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = vslpf_pkg::ST_MUL;
        end
      end
      vslpf_pkg::ST_MUL: begin
        state_nxt = vslpf_pkg::ST_UPD;
      end
      vslpf_pkg::ST_UPD: begin
        if (slot_free) begin
          state_nxt = vslpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vslpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.mul      = 1'b0;
    cmd.commit   = 1'b0;
    case (state_r)
      vslpf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      vslpf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      vslpf_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      vslpf_pkg::ST_UPD: begin
        cmd.commit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vslpf_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[rtl/vslpf_dp.sv]
// Datapath with the restoring alpha divider, the multiplier and the filter state.
`default_nettype none
module vslpf_dp (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  vslpf_pkg::cmd_t                             cmd,
  input  wire  [vslpf_pkg::TC_WIDTH-1:0]              time_constant,
  input  wire  signed [vslpf_pkg::SAMPLE_WIDTH-1:0]   in_sample,
  input  wire  [vslpf_pkg::DELTA_WIDTH-1:0]           in_time_delta,
  output logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0]   filtered
);

  localparam int SW = vslpf_pkg::SAMPLE_WIDTH;
  localparam int FB = vslpf_pkg::FRACTION_BITS;

  logic [vslpf_pkg::DEN_WIDTH-1:0]          den_r;
  logic [vslpf_pkg::DEN_WIDTH-1:0]          den_nxt;
  logic                                     den_zero_r;
  logic [vslpf_pkg::REM_WIDTH-1:0]          rem_r;
  logic [vslpf_pkg::REM_WIDTH-1:0]          rem_nxt;
  logic [vslpf_pkg::ALPHA_WIDTH-1:0]        quo_r;
  logic [vslpf_pkg::ALPHA_WIDTH-1:0]        quo_nxt;
  logic signed [vslpf_pkg::DIFF_WIDTH-1:0]  diff_r;
  logic signed [vslpf_pkg::DIFF_WIDTH-1:0]  diff_nxt;
  logic signed [vslpf_pkg::PROD_WIDTH-1:0]  prod_r;
  logic signed [vslpf_pkg::PROD_WIDTH-1:0]  prod_nxt;
  logic signed [SW-1:0]                     y_r;
  logic signed [SW-1:0]                     y_nxt;
  logic [vslpf_pkg::ALPHA_WIDTH-1:0]        alpha;
  logic [vslpf_pkg::REM_WIDTH-1:0]          den_ext;
  logic [vslpf_pkg::REM_WIDTH-1:0]          rem_sub;
  logic                                     rem_ge;

  assign den_nxt  = vslpf_pkg::DEN_WIDTH'(time_constant) +
                    vslpf_pkg::DEN_WIDTH'(in_time_delta);
  assign diff_nxt = $signed({in_sample[SW-1], in_sample}) - $signed({y_r[SW-1], y_r});

  // One quotient bit per step; the remainder is doubled after each trial subtraction.
  assign den_ext = vslpf_pkg::REM_WIDTH'(den_r);
  assign rem_ge  = rem_r >= den_ext;
  assign rem_sub = rem_ge ? (rem_r - den_ext) : rem_r;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.load) begin
      rem_nxt = vslpf_pkg::REM_WIDTH'(in_time_delta);
      quo_nxt = '0;
    end else if (cmd.div_step) begin
      rem_nxt = {rem_sub[vslpf_pkg::REM_WIDTH-2:0], 1'b0};
      quo_nxt = {quo_r[vslpf_pkg::ALPHA_WIDTH-2:0], rem_ge};
    end
  end

  assign alpha    = den_zero_r ? vslpf_pkg::ALPHA_WIDTH'(1) << FB : quo_r;
  assign prod_nxt = $signed({1'b0, alpha}) * diff_r;
  assign y_nxt    = y_r + prod_r[FB +: SW];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r      <= den_nxt;
      den_zero_r <= (den_nxt == '0);
      diff_r     <= diff_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r <= '0;
    end else if (cmd.commit) begin
      y_r <= y_nxt;
    end
  end

  assign filtered = y_r;

endmodule
`default_nettype wire

[rtl/variable_step_lowpass_filter.sv]
// Top level of the variable-step first-order low-pass filter.
`default_nettype none
`include "assert_macros.svh"
// Each request carries a signed sample and its time step dt; the block forms
// alpha = dt / (T + dt) as a truncated unsigned Q1.16 fraction (one when T + dt
// is zero), updates y = y + ((alpha * (x - y)) >>> 16) and returns the new y.
// The output starts at zero after reset. One request is processed at a time:
// after the accepting cycle, the one-bit-per-cycle restoring divider forms alpha,
// then a multiply step and an update step follow, and the result is registered
// at the output by the update. The update cycle is held while an earlier result
// still waits at the output. A new request is taken while the last result still
// waits at the output. The time constant T sits at APB address 0 and resets to
// 1000.
module variable_step_lowpass_filter (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  wire                                         in_valid,
  output logic                                        in_ready,
  input  wire  signed [vslpf_pkg::SAMPLE_WIDTH-1:0]   in_sample,
  input  wire  [vslpf_pkg::DELTA_WIDTH-1:0]           in_time_delta,
  output logic                                        out_valid,
  input  wire                                         out_ready,
  output logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0]   out_filtered,
  input  wire                                         psel,
  input  wire                                         penable,
  input  wire                                         pwrite,
  input  wire  [vslpf_pkg::PADDR_WIDTH-1:0]           paddr,
  input  wire  [vslpf_pkg::PDATA_WIDTH-1:0]           pwdata,
  output logic [vslpf_pkg::PDATA_WIDTH-1:0]           prdata,
  output logic                                        pready
);

  vslpf_pkg::cmd_t                 cmd;
  logic [vslpf_pkg::TC_WIDTH-1:0]  time_constant;

  vslpf_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .time_constant (time_constant)
  );

  vslpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  vslpf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .time_constant (time_constant),
    .in_sample     (in_sample),
    .in_time_delta (in_time_delta),
    .filtered      (out_filtered)
  );

  `VSLPF_ASSERT_ALWAYS(a_reset_no_result, !rst_n |=> !out_valid, "result valid after reset")
  `VSLPF_ASSERT(a_result_only_on_commit, !$stable(out_filtered) |-> $past(cmd.commit), "no commit")
  `VSLPF_ASSERT(a_no_result_after_accept, (in_valid && in_ready) |=> !$rose(out_valid), "early result")
  `VSLPF_ASSERT(a_commit_needs_slot, cmd.commit |-> (!out_valid || out_ready), "result overwritten")

endmodule
`default_nettype wire

[sim/tb_variable_step_lowpass_filter.sv]
// Self-checking testbench for the variable-step low-pass filter, with a built-in filter predictor.
`timescale 1ns / 100ps

module tb_variable_step_lowpass_filter;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PER_PHASE = 240;
  localparam int LONG_HOLD_AT = 400;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam logic [vslpf_pkg::PADDR_WIDTH-1:0] ADDR_TC = {vslpf_pkg::REG_TIME_CONSTANT, 2'b00};
  localparam logic [vslpf_pkg::PADDR_WIDTH-1:0] ADDR_UNUSED = vslpf_pkg::PADDR_WIDTH'(4);
  localparam logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MAX =
    {1'b0, {(vslpf_pkg::SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MIN =
    {1'b1, {(vslpf_pkg::SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [vslpf_pkg::DELTA_WIDTH-1:0] DELTA_MAX = '1;

  typedef struct {
    logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0] sample;
    logic [vslpf_pkg::DELTA_WIDTH-1:0] time_delta;
  } filter_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0] in_sample = '0;
  logic [vslpf_pkg::DELTA_WIDTH-1:0] in_time_delta = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0] out_filtered;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [vslpf_pkg::PADDR_WIDTH-1:0] paddr = '0;
  logic [vslpf_pkg::PDATA_WIDTH-1:0] pwdata = '0;
  logic [vslpf_pkg::PDATA_WIDTH-1:0] prdata;
  logic pready;

  filter_req_t pending_reqs[$];
  logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0] expected_outputs[$];
  logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0] filter_state = '0;
  logic [vslpf_pkg::TC_WIDTH-1:0] time_const = vslpf_pkg::TC_RESET;

  bit req_taken = 1'b0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;
  int recv_hold = 0;
  bit long_hold_done = 1'b0;
  int results_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  variable_step_lowpass_filter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample(in_sample),
    .in_time_delta(in_time_delta),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_filtered(out_filtered),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0] lowpass_next(
      logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0] x, logic [vslpf_pkg::DELTA_WIDTH-1:0] dt);
    longint den;
    longint alpha;
    longint diff;
    longint prod;
    den = longint'(time_const) + longint'(dt);
    if (den == 0) begin
      alpha = longint'(1) << vslpf_pkg::FRACTION_BITS;
    end else begin
      alpha = (longint'(dt) << vslpf_pkg::FRACTION_BITS) / den;
    end
    diff = longint'(x) - longint'(filter_state);
    prod = alpha * diff;
    return vslpf_pkg::SAMPLE_WIDTH'(longint'(filter_state) +
                                    (prod >>> vslpf_pkg::FRACTION_BITS));
  endfunction

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic filter_req_t random_req();
    filter_req_t req;
    logic [31:0] bits;
    int pick;
    int small_val;
    bits = $urandom;
    pick = $urandom_range(0, 9);
    small_val = int'($urandom_range(0, 32)) - 16;
    case (pick)
      0: req.sample = SAMPLE_MAX;
      1: req.sample = SAMPLE_MIN;
      2: req.sample = vslpf_pkg::SAMPLE_WIDTH'(small_val);
      default: req.sample = bits[vslpf_pkg::SAMPLE_WIDTH-1:0];
    endcase
    bits = $urandom;
    pick = $urandom_range(0, 9);
    case (pick)
      0: req.time_delta = '0;
      1: req.time_delta = DELTA_MAX;
      2, 3, 4: req.time_delta = vslpf_pkg::DELTA_WIDTH'($urandom_range(0, 2000));
      5, 6: req.time_delta = vslpf_pkg::DELTA_WIDTH'($urandom_range(0, 255));
      default: req.time_delta = bits[vslpf_pkg::DELTA_WIDTH-1:0];
    endcase
    return req;
  endfunction

  task automatic push_req(logic signed [vslpf_pkg::SAMPLE_WIDTH-1:0] s,
                          logic [vslpf_pkg::DELTA_WIDTH-1:0] dt);
    filter_req_t req;
    req.sample = s;
    req.time_delta = dt;
    pending_reqs.insert(pending_reqs.size(), req);
  endtask

  task automatic add_random_reqs(int count);
    repeat (count) pending_reqs.insert(pending_reqs.size(), random_req());
  endtask

  task automatic apb_write(logic [vslpf_pkg::PADDR_WIDTH-1:0] addr,
                           logic [vslpf_pkg::PDATA_WIDTH-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_TC) time_const = data[vslpf_pkg::TC_WIDTH-1:0];
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic random_phase(logic [vslpf_pkg::TC_WIDTH-1:0] tc,
                              logic [vslpf_pkg::PDATA_WIDTH-1:0] junk);
    apb_write(ADDR_TC, {junk[vslpf_pkg::PDATA_WIDTH-1:vslpf_pkg::TC_WIDTH], tc});
    @(posedge clk);
    add_random_reqs(RANDOM_PER_PHASE);
    wait_idle();
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Predict on every accepted request and check every accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        filter_state = lowpass_next(in_sample, in_time_delta);
        expected_outputs.insert(expected_outputs.size(), filter_state);
        req_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, out_filtered);
          mismatch_count++;
        end else begin
          if (out_filtered !== expected_outputs[0]) begin
            $display("%0t: filtered mismatch, expected %0d, actual %0d",
                     $time, expected_outputs[0], out_filtered);
            mismatch_count++;
          end
          void'(expected_outputs.pop_front());
        end
        results_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !req_taken)) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_sample <= pending_reqs[0].sample;
        in_time_delta <= pending_reqs[0].time_delta;
        void'(pending_reqs.pop_front());
        in_valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
        end else if ($urandom_range(0, 99) < 4) begin
          send_calm = $urandom_range(20, 80);
        end else begin
          send_gap = random_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && results_checked >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        recv_hold = LONG_HOLD_CYCLES;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else if ($urandom_range(0, 99) < 3) begin
          recv_calm = $urandom_range(50, 200);
        end else if ($urandom_range(0, 99) < 50) begin
          recv_stall = random_gap();
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_req(SAMPLE_MAX, vslpf_pkg::DELTA_WIDTH'(1000));
    push_req(SAMPLE_MAX, DELTA_MAX);
    push_req(SAMPLE_MIN, DELTA_MAX);
    push_req(SAMPLE_MIN, vslpf_pkg::DELTA_WIDTH'(1));
    push_req('0, '0);
    push_req(-vslpf_pkg::SAMPLE_WIDTH'(1), vslpf_pkg::DELTA_WIDTH'(1000));
    push_req(vslpf_pkg::SAMPLE_WIDTH'(1), vslpf_pkg::DELTA_WIDTH'(1000));
    push_req(SAMPLE_MAX, '0);
    wait_idle();

    apb_write(ADDR_TC, 32'hA5A5_0000);
    @(posedge clk);
    push_req(SAMPLE_MIN, '0);
    push_req(SAMPLE_MAX, '0);
    push_req(vslpf_pkg::SAMPLE_WIDTH'(123), vslpf_pkg::DELTA_WIDTH'(7));
    push_req(-vslpf_pkg::SAMPLE_WIDTH'(1), DELTA_MAX);
    wait_idle();

    apb_write(ADDR_TC, 32'h0000_FFFF);
    @(posedge clk);
    push_req(SAMPLE_MAX, DELTA_MAX);
    push_req(SAMPLE_MIN, DELTA_MAX);
    push_req(vslpf_pkg::SAMPLE_WIDTH'(5), vslpf_pkg::DELTA_WIDTH'(1));
    push_req(SAMPLE_MIN, '0);
    wait_idle();

    random_phase(vslpf_pkg::TC_WIDTH'(1), $urandom);
    random_phase(vslpf_pkg::TC_WIDTH'(1000), $urandom);
    apb_write(ADDR_UNUSED, $urandom);
    @(posedge clk);
    add_random_reqs(RANDOM_PER_PHASE);
    wait_idle();
    random_phase('1, $urandom);
    random_phase('0, $urandom);
    random_phase(vslpf_pkg::TC_WIDTH'($urandom_range(0, 65535)), $urandom);
    random_phase(vslpf_pkg::TC_WIDTH'(100), $urandom);

    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && expected_outputs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
